FILE: rtl/ipf_pkg.sv
package ipf_pkg;

  // Field widths fixed by the packet format.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 11;
  localparam int unsigned CrcW      = 16;
  localparam int unsigned LimitW    = 16;
  localparam int unsigned BeatIdxW  = 4;

  // Packet constants.
  localparam int unsigned MaxParams     = 1024;
  localparam int unsigned HdrOverhead   = 10;
  localparam int unsigned LenOverhead   = 3;
  localparam int unsigned HdrBeats      = 8;
  localparam logic [LimitW-1:0] LimitReset = 16'd143;
  localparam logic [CrcW-1:0]   CrcPoly    = 16'h8005;

  localparam logic [ByteW-1:0] HdrSync0 = 8'hFF;
  localparam logic [ByteW-1:0] HdrSync1 = 8'hFF;
  localparam logic [ByteW-1:0] HdrSync2 = 8'hFD;
  localparam logic [ByteW-1:0] HdrRsvd  = 8'h00;

  // Header beat positions.
  localparam logic [2:0] PosSync0 = 3'd0;
  localparam logic [2:0] PosSync1 = 3'd1;
  localparam logic [2:0] PosSync2 = 3'd2;
  localparam logic [2:0] PosRsvd  = 3'd3;
  localparam logic [2:0] PosId    = 3'd4;
  localparam logic [2:0] PosLenLo = 3'd5;
  localparam logic [2:0] PosLenHi = 3'd6;
  localparam logic [2:0] PosInstr = 3'd7;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_PARAM = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_STRAY    = 2'd2
  } status_e;

  // One input item as held in the input register.
  typedef struct packed {
    opcode_e             opcode;
    logic [ByteW-1:0]    device_id;
    logic [ByteW-1:0]    instruction;
    logic [CountW-1:0]   param_count;
    logic [ByteW-1:0]    param_byte;
  } item_t;

  // One output beat from the sequencer, with its end-of-item mark.
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             end_of_packet;
    status_e          status;
    logic             last;
  } beat_t;

  // CRC-16, polynomial 0x8005, MSB first, one byte.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Header byte at a given position of the packet.
  function automatic logic [ByteW-1:0] hdr_byte(input logic [2:0]        pos,
                                                input logic [ByteW-1:0]  dev,
                                                input logic [CrcW-1:0]   len,
                                                input logic [ByteW-1:0]  instr);
    logic [ByteW-1:0] r;
    case (pos)
      PosSync0: r = HdrSync0;
      PosSync1: r = HdrSync1;
      PosSync2: r = HdrSync2;
      PosRsvd:  r = HdrRsvd;
      PosId:    r = dev;
      PosLenLo: r = len[7:0];
      PosLenHi: r = len[15:8];
      PosInstr: r = instr;
      default:  r = HdrRsvd;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ipf_seq.sv
module ipf_seq import ipf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  item_t             item_i,
  input  logic              advance_i,
  input  logic [LimitW-1:0] max_bytes_i,
  output beat_t             beat_o
);

  logic [BeatIdxW-1:0] idx_q, idx_d;
  logic [CrcW-1:0]     crc_q, crc_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic                open_q, open_d;

  logic [CrcW-1:0]     crc_cur;
  logic [CrcW-1:0]     len;
  logic                too_long;
  logic                is_data;
  logic [ByteW-1:0]    data_byte;
  beat_t               beat;

  // A begin starts its CRC from zero, abandoning any open packet.
  assign crc_cur  = (item_i.opcode == OP_BEGIN && idx_q == '0) ? '0 : crc_q;
  assign len      = CrcW'(item_i.param_count) + CrcW'(LenOverhead);
  assign too_long = (32'(item_i.param_count) > 32'(MaxParams)) ||
                    ((17'(item_i.param_count) + 17'(HdrOverhead)) > 17'(max_bytes_i));

  // Select the beat for the current position and the next packet state.
  always_comb begin
    beat      = '{out_byte: '0, end_of_packet: 1'b0, status: ST_OK, last: 1'b0};
    is_data   = 1'b0;
    data_byte = '0;
    open_d    = open_q;
    rem_d     = rem_q;
    crc_d     = crc_q;
    if (item_i.opcode == OP_BEGIN) begin
      if (too_long) begin
        beat.end_of_packet = 1'b1;
        beat.status        = ST_TOO_LONG;
        beat.last          = 1'b1;
        open_d             = 1'b0;
        rem_d              = '0;
        crc_d              = '0;
      end else if (idx_q < BeatIdxW'(HdrBeats)) begin
        is_data   = 1'b1;
        data_byte = hdr_byte(idx_q[2:0], item_i.device_id, len, item_i.instruction);
        if (idx_q == '0) begin
          open_d = 1'b0;
          rem_d  = '0;
        end
        if (idx_q == BeatIdxW'(HdrBeats - 1)) begin
          open_d    = (item_i.param_count != '0);
          rem_d     = item_i.param_count;
          beat.last = (item_i.param_count != '0);
        end
      end else if (idx_q == BeatIdxW'(HdrBeats)) begin
        beat.out_byte = crc_q[7:0];
      end else begin
        beat.out_byte      = crc_q[15:8];
        beat.end_of_packet = 1'b1;
        beat.last          = 1'b1;
        open_d             = 1'b0;
        rem_d              = '0;
        crc_d              = '0;
      end
    end else begin
      if (idx_q == '0) begin
        if (!open_q) begin
          beat.end_of_packet = 1'b1;
          beat.status        = ST_STRAY;
          beat.last          = 1'b1;
        end else begin
          is_data   = 1'b1;
          data_byte = item_i.param_byte;
          rem_d     = rem_q - CountW'(1);
          beat.last = (rem_q != CountW'(1));
        end
      end else if (idx_q == BeatIdxW'(1)) begin
        beat.out_byte = crc_q[7:0];
      end else begin
        beat.out_byte      = crc_q[15:8];
        beat.end_of_packet = 1'b1;
        beat.last          = 1'b1;
        open_d             = 1'b0;
        rem_d              = '0;
        crc_d              = '0;
      end
    end
    if (is_data) begin
      beat.out_byte = data_byte;
      crc_d         = crc_byte(crc_cur, data_byte);
    end
    idx_d = beat.last ? '0 : idx_q + BeatIdxW'(1);
  end

  assign beat_o = beat;

  // Packet state advances once per emitted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      crc_q  <= '0;
      rem_q  <= '0;
      open_q <= 1'b0;
    end else if (advance_i) begin
      idx_q  <= idx_d;
      crc_q  <= crc_d;
      rem_q  <= rem_d;
      open_q <= open_d;
    end
  end

endmodule

FILE: rtl/instruction_packet_framer_crc16_top.sv
// The first beat of an item passes the input register and then the output register;
// a stall can hold it in either. Output rate: one beat per cycle while not stalled.
// One sequencer makes the beats. A parameter gives its byte, the last one adds the CRC;
// a begin gives the header, adding the CRC if empty, or just an error beat if rejected.
// Reset: no packet open, CRC cleared, both registers empty, length limit 143 bytes.
module instruction_packet_framer_crc16_top import ipf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [ByteW-1:0]  device_id_i,
  input  logic [ByteW-1:0]  instruction_i,
  input  logic [CountW-1:0] param_count_i,
  input  logic [ByteW-1:0]  param_byte_i,
  // Output channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ByteW-1:0]  out_byte_o,
  output logic              end_of_packet_o,
  output logic [1:0]        status_o,
  // Configuration channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_max_packet_bytes_i
);

  logic              in_vld_q;
  item_t             item_q;
  logic              out_vld_q;
  logic [ByteW-1:0]  out_byte_q;
  logic              out_eop_q;
  status_e           out_status_q;
  logic [LimitW-1:0] max_bytes_q;
  logic              fire;
  logic              in_accept;
  beat_t             beat;

  // A beat is produced when an item is held and the output register is empty or being read.
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !(fire && beat.last);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Length limit register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bytes_q <= cfg_max_packet_bytes_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (fire && beat.last) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{opcode:      opcode_e'(opcode_i),
                 device_id:   device_id_i,
                 instruction: instruction_i,
                 param_count: param_count_i,
                 param_byte:  param_byte_i};
    end
  end

  ipf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_q),
    .advance_i   (fire),
    .max_bytes_i (max_bytes_q),
    .beat_o      (beat)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q   <= beat.out_byte;
      out_eop_q    <= beat.end_of_packet;
      out_status_q <= beat.status;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_byte_o      = out_byte_q;
  assign end_of_packet_o = out_eop_q;
  assign status_o        = out_status_q;

  // An empty input register never holds off the input.
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !in_stall_o)
    else $error("input stalled with no item held");

  // Error beats carry a zero byte and close the packet.
  a_error_beat_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (end_of_packet_o && out_byte_o == '0))
    else $error("malformed error beat");

  // A new output beat appears only after the sequencer fired.
  a_out_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fire))
    else $error("output beat without sequencer step");

endmodule

FILE: bench/instruction_packet_framer_crc16_top_tb.sv
module instruction_packet_framer_crc16_top_tb;
  import ipf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime ClkPeriod = 10ns;
  localparam int CycleLimit = 400000;

  // One expected output beat.
  typedef struct {
    logic [ByteW-1:0] data;
    logic             eop;
    status_e          st;
  } beat_exp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              opcode_i = 1'b0;
  logic [ByteW-1:0]  device_id_i = '0;
  logic [ByteW-1:0]  instruction_i = '0;
  logic [CountW-1:0] param_count_i = '0;
  logic [ByteW-1:0]  param_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ByteW-1:0]  out_byte_o;
  logic              end_of_packet_o;
  logic [1:0]        status_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_max_packet_bytes_i = '0;

  // Shadow of the framer state.
  logic [LimitW-1:0] limit_bytes;
  logic [CrcW-1:0]   crc_acc;
  logic [CountW-1:0] params_left;
  logic              pkt_open;
  beat_exp_t         frame_beats_q[$];

  int errors = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  int hold_req = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit burst_stall = 1'b0;
  beat_exp_t got_exp;

  instruction_packet_framer_crc16_top dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .opcode_i               (opcode_i),
    .device_id_i            (device_id_i),
    .instruction_i          (instruction_i),
    .param_count_i          (param_count_i),
    .param_byte_i           (param_byte_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_byte_o             (out_byte_o),
    .end_of_packet_o        (end_of_packet_o),
    .status_o               (status_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_max_packet_bytes_i (cfg_max_packet_bytes_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Runaway guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // CRC-16, polynomial 0x8005, fed one bit at a time from the MSB.
  function automatic logic [CrcW-1:0] crc16_step(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = c[CrcW-1] ^ b[i];
      c = {c[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return c;
  endfunction

  function automatic void push_beat(input logic [ByteW-1:0] data, input logic eop,
                                    input status_e st);
    beat_exp_t e;
    e.data = data;
    e.eop = eop;
    e.st = st;
    frame_beats_q.push_back(e);
  endfunction

  function automatic void put_data(input logic [ByteW-1:0] b);
    crc_acc = crc16_step(crc_acc, b);
    push_beat(b, 1'b0, ST_OK);
  endfunction

  // Append the CRC, low byte first, and close the packet.
  function automatic void close_frame();
    push_beat(crc_acc[7:0], 1'b0, ST_OK);
    push_beat(crc_acc[15:8], 1'b1, ST_OK);
    pkt_open = 1'b0;
    params_left = '0;
    crc_acc = '0;
  endfunction

  // Expected beats for one accepted input item.
  function automatic void frame_item(input opcode_e op, input logic [ByteW-1:0] dev,
                                     input logic [ByteW-1:0] instr,
                                     input logic [CountW-1:0] cnt,
                                     input logic [ByteW-1:0] pb);
    logic [CrcW-1:0] len;
    if (op == OP_BEGIN) begin
      // A begin always drops whatever packet was open.
      pkt_open = 1'b0;
      params_left = '0;
      crc_acc = '0;
      if (32'(cnt) > MaxParams || 32'(cnt) + HdrOverhead > 32'(limit_bytes)) begin
        push_beat('0, 1'b1, ST_TOO_LONG);
        return;
      end
      len = 16'(cnt) + 16'(LenOverhead);
      put_data(HdrSync0);
      put_data(HdrSync1);
      put_data(HdrSync2);
      put_data(HdrRsvd);
      put_data(dev);
      put_data(len[7:0]);
      put_data(len[15:8]);
      put_data(instr);
      if (cnt == '0) begin
        close_frame();
      end else begin
        pkt_open = 1'b1;
        params_left = cnt;
      end
    end else if (!pkt_open) begin
      push_beat('0, 1'b1, ST_STRAY);
    end else begin
      put_data(pb);
      params_left = params_left - CountW'(1);
      if (params_left == '0) begin
        close_frame();
      end
    end
  endfunction

  // Offer one input beat until it is taken, then maybe leave a gap.
  task automatic send_item(input opcode_e op, input logic [ByteW-1:0] dev,
                           input logic [ByteW-1:0] instr, input logic [CountW-1:0] cnt,
                           input logic [ByteW-1:0] pb);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    device_id_i <= dev;
    instruction_i <= instr;
    param_count_i <= cnt;
    param_byte_i <= pb;
    do @(posedge clk_i); while (in_stall_o);
    frame_item(op, dev, instr, cnt, pb);
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Unused fields carry random values so the block must ignore them.
  task automatic send_begin(input logic [ByteW-1:0] dev, input logic [ByteW-1:0] instr,
                            input logic [CountW-1:0] cnt);
    send_item(OP_BEGIN, dev, instr, cnt, 8'($urandom));
  endtask

  task automatic send_param(input logic [ByteW-1:0] pb);
    send_item(OP_PARAM, 8'($urandom), 8'($urandom), 11'($urandom), pb);
  endtask

  // Stop offering and wait until every expected beat has come out.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frame_beats_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_packet_limit(input logic [LimitW-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_max_packet_bytes_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_bytes = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Output side: random stall bursts, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!idle_on) begin
      out_stall_i <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_stall = ($urandom_range(0, 2) == 0);
        burst_left = burst_stall ? $urandom_range(1, 8) : $urandom_range(1, 24);
      end
      burst_left--;
      out_stall_i <= burst_stall;
    end
  end

  // Compare each output beat with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_beats_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %h eop %b status %0d",
                 $time, out_byte_o, end_of_packet_o, status_o);
        errors++;
      end else begin
        got_exp = frame_beats_q.pop_front();
        beats_checked++;
        if (out_byte_o !== got_exp.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, got_exp.data, out_byte_o);
          errors++;
        end
        if (end_of_packet_o !== got_exp.eop) begin
          $display("%0t: end_of_packet expected %b actual %b", $time, got_exp.eop,
                   end_of_packet_o);
          errors++;
        end
        if (status_o !== got_exp.st) begin
          $display("%0t: status expected %0d actual %0d", $time, got_exp.st, status_o);
          errors++;
        end
      end
    end
  end

  // Field extremes, empty packets, abandon, rejects and stray bytes at the reset limit.
  task automatic test_directed();
    send_param(8'h5A);
    send_begin(8'h00, 8'h00, 11'd0);
    send_begin(8'hFF, 8'hFF, 11'd0);
    send_begin(8'hFE, 8'h03, 11'd2);
    send_param(8'h00);
    send_param(8'hFF);
    send_begin(8'h01, 8'h83, 11'd4);
    send_param(8'h12);
    send_param(8'h34);
    send_begin(8'h07, 8'h02, 11'd1);
    send_param(8'hAA);
    send_begin(8'h02, 8'h01, 11'h7FF);
    send_param(8'h55);
    send_begin(8'h03, 8'h01, 11'd134);
    send_begin(8'h04, 8'h01, 11'd1025);
    send_param(8'hC3);
  endtask

  // Length limit at both extremes and at exact boundaries.
  task automatic test_packet_limit();
    write_packet_limit(16'd10);
    send_begin(8'h11, 8'h22, 11'd0);
    send_begin(8'h11, 8'h22, 11'd1);
    write_packet_limit(16'd9);
    send_begin(8'h33, 8'h44, 11'd0);
    write_packet_limit(16'd0);
    send_begin(8'h33, 8'h44, 11'd0);
    write_packet_limit(16'd20);
    send_begin(8'h55, 8'h66, 11'd10);
    repeat (10) send_param(8'($urandom));
    send_begin(8'h55, 8'h66, 11'd11);
    // Largest packet header: the length high byte becomes nonzero. The packet is
    // then abandoned by the next begin.
    write_packet_limit(16'hFFFF);
    send_begin(8'h77, 8'h88, 11'd1024);
    repeat (4) send_param(8'($urandom));
    send_begin(8'h77, 8'h88, 11'd1025);
    send_begin(8'h77, 8'h88, 11'h7FF);
    write_packet_limit(16'd1033);
    send_begin(8'h99, 8'hAA, 11'd1024);
  endtask

  // Mostly whole packets with random content, some cut short, stray bytes and rejects.
  task automatic random_traffic(input int n_items);
    int sent;
    int pick;
    int cnt;
    int nparams;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        send_begin(8'($urandom), 8'($urandom), 11'(cnt));
        nparams = (pick == 14) ? $urandom_range(0, cnt) : cnt;
        repeat (nparams) send_param(8'($urandom));
        sent += 1 + nparams;
      end else if (pick < 17) begin
        send_param(8'($urandom));
        sent++;
      end else begin
        cnt = int'(limit_bytes) - 9 + $urandom_range(0, 40);
        if (cnt > 2047) begin
          cnt = $urandom_range(1025, 2047);
        end else if (cnt < 0) begin
          cnt = $urandom_range(0, 40);
        end
        send_begin(8'($urandom), 8'($urandom), 11'(cnt));
        sent++;
      end
    end
  endtask

  task automatic test_random_limits();
    write_packet_limit(LimitReset);
    random_traffic(50);
    write_packet_limit(16'($urandom_range(10, 40)));
    random_traffic(50);
    write_packet_limit(16'($urandom_range(41, 400)));
    random_traffic(50);
    write_packet_limit(16'hFFFF);
    random_traffic(50);
  endtask

  // Output held off for a long stretch while a packet keeps coming in.
  task automatic test_backpressure();
    write_packet_limit(LimitReset);
    hold_req = 120;
    send_begin(8'h2A, 8'h03, 11'd40);
    repeat (40) send_param(8'($urandom));
    wait_idle();
  endtask

  // Back-to-back beats on both sides.
  task automatic test_full_rate();
    idle_on = 1'b0;
    random_traffic(40);
  endtask

  initial begin
    limit_bytes = LimitReset;
    crc_acc = '0;
    params_left = '0;
    pkt_open = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_packet_limit();
    test_random_limits();
    test_backpressure();
    test_full_rate();

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d input items and checked %0d output beats in %0d cycles,",
             items_sent, beats_checked, cycle_count);
    $display("with length limits from 0 to 65535, stray bytes, rejects and stalls.");
    if (errors == 0 && frame_beats_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d beats still expected", errors, frame_beats_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
